FILE: src/gtsa_pkg.sv
// Shared types and constants for the guaranteed-time-slot allocator.
// No dependencies; imported by every module of the block.
package gtsa_pkg;

  localparam int OWNER_W  = 16;
  localparam int LEN_W    = 4;
  localparam int TS_W     = 6;
  localparam int BASE_W   = 10;
  localparam int MINCAP_W = 16;
  localparam int ORDER_W  = 4;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W   = TS_W + BASE_W;
  localparam int SHIFT_W  = PROD_W + (2 ** ORDER_W) - 1;

  localparam int MAX_GRANTS_DEF = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SLOTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SLOT_DUR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CAP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SF_ORDER      = 2'd3;

  localparam logic [TS_W-1:0]     RST_TOTAL_SLOTS = 6'd16;
  localparam logic [BASE_W-1:0]   RST_BASE_SLOT   = 10'd60;
  localparam logic [MINCAP_W-1:0] RST_MIN_CAP     = 16'd440;
  localparam logic [ORDER_W-1:0]  RST_SF_ORDER    = 4'd0;

  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_BEACON  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;

  typedef struct packed {
    logic init;
    logic req_step;
    logic req_mul;
    logic req_decide;
    logic bcn_emit;
    logic bcn_close;
  } gtsa_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic bcn_fits;
  } gtsa_stat_t;

endpackage

FILE: src/gts_slot_allocator.sv
// Channel   | handshake          | payload
// ----------+--------------------+----------------------------------------------
// request   | start / busy       | func, source_id, request_length
// result    | result_valid       | kind, granted_length, entry_owner, entry_length,
//           |  (one-cycle beat)  |   entry_start, cap_length, list_cleared, last
// config    | cfg_we             | cfg_index, cfg_data
//
// A request gets a single answer beat; a beacon gives grant_count + 1 beats (fewer
// on a corrupt table), one per cycle. Both walk the grant table one entry per cycle
// on its single read port. busy drops with the final beat, so the next item can be
// taken in the cycle that beat is shown. Synchronous reset empties the table and
// restores the registers. The result side has no back-pressure.
module gts_slot_allocator
  import gtsa_pkg::*;
#(
  parameter int MAX_GRANTS = MAX_GRANTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func,
  input  logic [OWNER_W-1:0]    source_id,
  input  logic [LEN_W-1:0]      request_length,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  output logic [KIND_W-1:0]     kind,
  output logic [LEN_W-1:0]      granted_length,
  output logic [OWNER_W-1:0]    entry_owner,
  output logic [LEN_W-1:0]      entry_length,
  output logic [TS_W-1:0]       entry_start,
  output logic [TS_W-1:0]       cap_length,
  output logic                  list_cleared,
  output logic                  last
);

  logic [TS_W-1:0]     total_slots;
  logic [BASE_W-1:0]   base_slot_duration;
  logic [MINCAP_W-1:0] min_cap_length;
  logic [ORDER_W-1:0]  superframe_order;
  gtsa_cmd_t           cmd;
  gtsa_stat_t          stat;

  gtsa_regs u_regs (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .total_slots        (total_slots),
    .base_slot_duration (base_slot_duration),
    .min_cap_length     (min_cap_length),
    .superframe_order   (superframe_order)
  );

  gtsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  gtsa_dp #(
    .MAX_GRANTS (MAX_GRANTS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .source_id          (source_id),
    .request_length     (request_length),
    .total_slots        (total_slots),
    .base_slot_duration (base_slot_duration),
    .min_cap_length     (min_cap_length),
    .superframe_order   (superframe_order),
    .result_valid       (result_valid),
    .kind               (kind),
    .granted_length     (granted_length),
    .entry_owner        (entry_owner),
    .entry_length       (entry_length),
    .entry_start        (entry_start),
    .cap_length         (cap_length),
    .list_cleared       (list_cleared),
    .last               (last)
  );

endmodule

FILE: src/gtsa_regs.sv
// Configuration registers of the slot allocator.
// Depends on gtsa_pkg for widths, indexes and reset values.
module gtsa_regs
  import gtsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [TS_W-1:0]       total_slots,
  output logic [BASE_W-1:0]     base_slot_duration,
  output logic [MINCAP_W-1:0]   min_cap_length,
  output logic [ORDER_W-1:0]    superframe_order
);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_slots        <= RST_TOTAL_SLOTS;
      base_slot_duration <= RST_BASE_SLOT;
      min_cap_length     <= RST_MIN_CAP;
      superframe_order   <= RST_SF_ORDER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL_SLOTS:   total_slots        <= cfg_data[TS_W-1:0];
        REG_BASE_SLOT_DUR: base_slot_duration <= cfg_data[BASE_W-1:0];
        REG_MIN_CAP:       min_cap_length     <= cfg_data[MINCAP_W-1:0];
        REG_SF_ORDER:      superframe_order   <= cfg_data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/gtsa_ctrl.sv
// Sequencer for the slot allocator: walks the grant table via datapath commands.
// Depends on gtsa_pkg for the command and status structs.
module gtsa_ctrl
  import gtsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       func,
  input  gtsa_stat_t stat,
  output gtsa_cmd_t  cmd,
  output logic       busy
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_REQ_SCAN = 2'd1;
  localparam logic [1:0] ST_REQ_DEC  = 2'd2;
  localparam logic [1:0] ST_BCN_SCAN = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.init   = 1'b1;
          state_next = (func == FUNC_BEACON) ? ST_BCN_SCAN : ST_REQ_SCAN;
        end
      end
      ST_REQ_SCAN: begin
        if (stat.scan_done) begin
          cmd.req_mul = 1'b1;
          state_next  = ST_REQ_DEC;
        end else begin
          cmd.req_step = 1'b1;
        end
      end
      ST_REQ_DEC: begin
        cmd.req_decide = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_BCN_SCAN: begin
        // an entry that does not fit ends the walk: close with the table cleared
        if (stat.scan_done || !stat.bcn_fits) begin
          cmd.bcn_close = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.bcn_emit = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: src/gtsa_dp.sv
// Datapath of the slot allocator: grant table, scan pointers, CAP arithmetic, result register.
// Depends on gtsa_pkg; driven by gtsa_ctrl commands.
module gtsa_dp
  import gtsa_pkg::*;
#(
  parameter int MAX_GRANTS = MAX_GRANTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  gtsa_cmd_t           cmd,
  output gtsa_stat_t          stat,
  input  logic [OWNER_W-1:0]  source_id,
  input  logic [LEN_W-1:0]    request_length,
  input  logic [TS_W-1:0]     total_slots,
  input  logic [BASE_W-1:0]   base_slot_duration,
  input  logic [MINCAP_W-1:0] min_cap_length,
  input  logic [ORDER_W-1:0]  superframe_order,
  output logic                result_valid,
  output logic [KIND_W-1:0]   kind,
  output logic [LEN_W-1:0]    granted_length,
  output logic [OWNER_W-1:0]  entry_owner,
  output logic [LEN_W-1:0]    entry_length,
  output logic [TS_W-1:0]     entry_start,
  output logic [TS_W-1:0]     cap_length,
  output logic                list_cleared,
  output logic                last
);

  localparam int CNT_W = $clog2(MAX_GRANTS + 1);
  localparam int IDX_W = (MAX_GRANTS > 1) ? $clog2(MAX_GRANTS) : 1;
  localparam int CAP_W = LEN_W + CNT_W + 2;

  logic [OWNER_W-1:0] grant_owner [MAX_GRANTS];
  logic [LEN_W-1:0]   grant_length [MAX_GRANTS];
  logic [CNT_W-1:0]   grant_count;

  logic [OWNER_W-1:0] src;
  logic [LEN_W-1:0]   req;
  logic [CNT_W-1:0]   rd, wr;
  logic signed [CAP_W-1:0] cap;
  logic               hit;
  logic               neg;
  logic [PROD_W-1:0]  prod;

  logic [OWNER_W-1:0] rd_owner;
  logic [LEN_W-1:0]   rd_len;
  logic               owner_match, do_copy, do_sub;
  logic signed [CAP_W-1:0] diff;
  logic [SHIFT_W-1:0] need;
  logic               refuse;
  logic [TS_W-1:0]    cap_u, cap_after;

  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_wa;
  logic [OWNER_W-1:0] tbl_wowner;
  logic [LEN_W-1:0]   tbl_wlen;

  assign rd_owner = grant_owner[rd[IDX_W-1:0]];
  assign rd_len   = grant_length[rd[IDX_W-1:0]];

  assign stat.scan_done = (rd == grant_count);
  assign cap_u          = cap[TS_W-1:0];
  assign stat.bcn_fits  = (cap_u > TS_W'(rd_len));
  assign cap_after      = cap_u - TS_W'(rd_len);

  // request walk: a matching owner with the same length keeps everything after it
  assign owner_match = (rd_owner == src);
  assign do_copy     = hit || !owner_match || (rd_len == req);
  assign do_sub      = !hit && !owner_match;

  assign diff   = cap - $signed({{(CAP_W-LEN_W){1'b0}}, req});
  assign need   = SHIFT_W'(prod) << superframe_order;
  assign refuse = neg || (need < SHIFT_W'(min_cap_length)) || (wr >= CNT_W'(MAX_GRANTS));

  always_comb begin
    tbl_we     = 1'b0;
    tbl_wa     = wr[IDX_W-1:0];
    tbl_wowner = rd_owner;
    tbl_wlen   = rd_len;
    if (cmd.req_step) begin
      tbl_we = do_copy;
    end else if (cmd.req_decide) begin
      tbl_we     = !hit && !refuse;
      tbl_wowner = src;
      tbl_wlen   = req;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      grant_owner[tbl_wa]  <= tbl_wowner;
      grant_length[tbl_wa] <= tbl_wlen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grant_count <= '0;
    end else if (cmd.req_decide) begin
      grant_count <= (!hit && !refuse) ? wr + 1'b1 : wr;
    end else if (cmd.bcn_close && !stat.scan_done) begin
      grant_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      src <= source_id;
      req <= request_length;
      rd  <= '0;
      wr  <= '0;
      hit <= 1'b0;
      cap <= $signed({{(CAP_W-TS_W){1'b0}}, total_slots});
    end
    if (cmd.req_step) begin
      rd <= rd + 1'b1;
      if (do_copy) wr <= wr + 1'b1;
      if (do_sub) cap <= cap - $signed({{(CAP_W-LEN_W){1'b0}}, rd_len});
      if (!hit && owner_match && rd_len == req) hit <= 1'b1;
    end
    if (cmd.req_mul) begin
      // diff is at most total_slots, so its low bits carry the whole positive value
      neg  <= diff[CAP_W-1];
      prod <= PROD_W'(diff[TS_W-1:0]) * PROD_W'(base_slot_duration);
    end
    if (cmd.bcn_emit) begin
      rd  <= rd + 1'b1;
      cap <= $signed({{(CAP_W-TS_W){1'b0}}, cap_after});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.req_decide || cmd.bcn_emit || cmd.bcn_close;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_decide) begin
      kind           <= KIND_ANSWER;
      granted_length <= (hit || !refuse) ? req : '0;
      entry_owner    <= '0;
      entry_length   <= '0;
      entry_start    <= '0;
      cap_length     <= '0;
      list_cleared   <= 1'b0;
      last           <= 1'b1;
    end else if (cmd.bcn_emit) begin
      kind           <= KIND_ENTRY;
      granted_length <= '0;
      entry_owner    <= rd_owner;
      entry_length   <= rd_len;
      entry_start    <= cap_after + 1'b1;
      cap_length     <= '0;
      list_cleared   <= 1'b0;
      last           <= 1'b0;
    end else if (cmd.bcn_close) begin
      kind           <= KIND_CLOSE;
      granted_length <= '0;
      entry_owner    <= '0;
      entry_length   <= '0;
      entry_start    <= '0;
      cap_length     <= stat.scan_done ? cap_u : total_slots;
      list_cleared   <= !stat.scan_done;
      last           <= 1'b1;
    end
  end

endmodule

FILE: src/gtsa_checker.sv
// Port-level checks for gts_slot_allocator, attached by bind.
// Depends on gtsa_pkg for the result kind codes.
module gtsa_checker
  import gtsa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input logic [KIND_W-1:0] kind,
  input logic              last
);

  // an accepted item keeps the block busy until its final beat
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // beacon entries come back to back: a non-final beat is always followed by another
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("gap inside a result stream");

  // only beacon entries are non-final
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last == (kind != KIND_ENTRY)))
    else $error("last flag does not match result kind");

  // busy drops exactly when the final beat appears
  a_fell_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> result_valid && last)
    else $error("busy dropped without a final beat");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (busy == !last))
    else $error("busy inconsistent with result beat");

endmodule

bind gts_slot_allocator gtsa_checker u_gtsa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .kind         (kind),
  .last         (last)
);

FILE: tb/sv/gtsa_checker.sv
// Scoreboard for gts_slot_allocator: keeps its own grant table and register copy,
// predicts every result beat and compares it field by field.
// Depends on gtsa_pkg for widths, register indexes and result kinds.
module gtsa_scoreboard
  import gtsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  func,
  input  logic [OWNER_W-1:0]    source_id,
  input  logic [LEN_W-1:0]      request_length,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  result_valid,
  input  logic [KIND_W-1:0]     kind,
  input  logic [LEN_W-1:0]      granted_length,
  input  logic [OWNER_W-1:0]    entry_owner,
  input  logic [LEN_W-1:0]      entry_length,
  input  logic [TS_W-1:0]       entry_start,
  input  logic [TS_W-1:0]       cap_length,
  input  logic                  list_cleared,
  input  logic                  last,
  output int                    mismatch_count,
  output int                    beats_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LEN_W-1:0]   granted;
    logic [OWNER_W-1:0] owner;
    logic [LEN_W-1:0]   elen;
    logic [TS_W-1:0]    estart;
    logic [TS_W-1:0]    cap;
    logic               cleared;
    logic               last;
  } slot_beat_t;

  logic [TS_W-1:0]     slots_total;
  logic [BASE_W-1:0]   slot_base;
  logic [MINCAP_W-1:0] cap_floor;
  logic [ORDER_W-1:0]  sf_order;

  logic [OWNER_W-1:0] tbl_owner [MAX_GRANTS_DEF];
  logic [LEN_W-1:0]   tbl_len   [MAX_GRANTS_DEF];
  int                 tbl_count;

  slot_beat_t beats_due [$];
  slot_beat_t want_beat;
  slot_beat_t new_beat;
  logic [LEN_W-1:0] grant;

  initial begin
    mismatch_count = 0;
    beats_pending  = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t gtsa mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  // Same owner and length keeps the table as is; same owner with another
  // length drops the old grant and the request is weighed as a new one.
  task automatic answer_request(input logic [OWNER_W-1:0] src, input logic [LEN_W-1:0] req,
                                output logic [LEN_W-1:0] granted);
    longint slots_left;
    longint need;
    int     rd;
    int     wr;
    int     k;
    bit     kept;
    slots_left = longint'(slots_total);
    wr = 0;
    kept = 0;
    granted = '0;
    for (rd = 0; rd < tbl_count && !kept; rd++) begin
      if (tbl_owner[rd] == src && tbl_len[rd] == req) begin
        for (k = rd; k < tbl_count; k++) begin
          tbl_owner[wr] = tbl_owner[k];
          tbl_len[wr] = tbl_len[k];
          wr++;
        end
        granted = req;
        kept = 1;
      end else if (tbl_owner[rd] != src) begin
        slots_left = slots_left - longint'(tbl_len[rd]);
        tbl_owner[wr] = tbl_owner[rd];
        tbl_len[wr] = tbl_len[rd];
        wr++;
      end
    end
    tbl_count = wr;
    if (!kept) begin
      need = (slots_left - longint'(req)) * longint'(slot_base)
             * (longint'(1) << sf_order);
      if (wr < MAX_GRANTS_DEF && need >= longint'(cap_floor)) begin
        tbl_owner[wr] = src;
        tbl_len[wr] = req;
        tbl_count = wr + 1;
        granted = req;
      end
    end
  endtask

  // Slots are handed out from the top of the superframe downwards; a grant
  // that does not fit below the running CAP means the table is corrupt.
  task automatic list_beacon();
    logic [TS_W-1:0] cap;
    slot_beat_t      b;
    bit              cleared;
    int              i;
    cap = slots_total;
    cleared = 0;
    for (i = 0; i < tbl_count && !cleared; i++) begin
      if (cap > tbl_len[i]) begin
        cap = cap - tbl_len[i];
        b = '0;
        b.kind = KIND_ENTRY;
        b.owner = tbl_owner[i];
        b.elen = tbl_len[i];
        b.estart = cap + 1'b1;
        beats_due = {beats_due, b};
      end else begin
        tbl_count = 0;
        cap = slots_total;
        cleared = 1;
      end
    end
    b = '0;
    b.kind = KIND_CLOSE;
    b.cap = cap;
    b.cleared = cleared;
    b.last = 1'b1;
    beats_due = {beats_due, b};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      slots_total = RST_TOTAL_SLOTS;
      slot_base = RST_BASE_SLOT;
      cap_floor = RST_MIN_CAP;
      sf_order = RST_SF_ORDER;
      tbl_count = 0;
      beats_due.delete();
    end else begin
      if (result_valid) begin
        if (beats_due.size() == 0) begin
          report_mismatch($sformatf("beat of kind %0d with nothing due", kind));
        end else begin
          want_beat = beats_due.pop_front();
          check_field("kind", 16'(want_beat.kind), 16'(kind));
          check_field("granted_length", 16'(want_beat.granted), 16'(granted_length));
          check_field("entry_owner", want_beat.owner, entry_owner);
          check_field("entry_length", 16'(want_beat.elen), 16'(entry_length));
          check_field("entry_start", 16'(want_beat.estart), 16'(entry_start));
          check_field("cap_length", 16'(want_beat.cap), 16'(cap_length));
          check_field("list_cleared", 16'(want_beat.cleared), 16'(list_cleared));
          check_field("last", 16'(want_beat.last), 16'(last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TOTAL_SLOTS:   slots_total = cfg_data[TS_W-1:0];
          REG_BASE_SLOT_DUR: slot_base = cfg_data[BASE_W-1:0];
          REG_MIN_CAP:       cap_floor = cfg_data[MINCAP_W-1:0];
          REG_SF_ORDER:      sf_order = cfg_data[ORDER_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (func == FUNC_REQUEST) begin
          answer_request(source_id, request_length, grant);
          new_beat = '0;
          new_beat.kind = KIND_ANSWER;
          new_beat.granted = grant;
          new_beat.last = 1'b1;
          beats_due = {beats_due, new_beat};
        end else begin
          list_beacon();
        end
      end
    end
    beats_pending <= beats_due.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the gts_slot_allocator regression: clock, reset, stimulus and verdict.
// Depends on gtsa_pkg, the gts_slot_allocator RTL and gtsa_scoreboard.
module testbench;
  import gtsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 250000;
  localparam int SETTLE_CYCLES = 14;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 33;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  func = FUNC_REQUEST;
  logic [OWNER_W-1:0]    source_id = '0;
  logic [LEN_W-1:0]      request_length = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  result_valid;
  logic [KIND_W-1:0]     kind;
  logic [LEN_W-1:0]      granted_length;
  logic [OWNER_W-1:0]    entry_owner;
  logic [LEN_W-1:0]      entry_length;
  logic [TS_W-1:0]       entry_start;
  logic [TS_W-1:0]       cap_length;
  logic                  list_cleared;
  logic                  last;
  int                    mismatch_count;
  int                    beats_pending;
  int unsigned           cycle_count = 0;
  logic [OWNER_W-1:0]    id_pool [10];

  always #4 clk = ~clk;

  gts_slot_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .source_id(source_id), .request_length(request_length),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .kind(kind), .granted_length(granted_length),
    .entry_owner(entry_owner), .entry_length(entry_length),
    .entry_start(entry_start), .cap_length(cap_length),
    .list_cleared(list_cleared), .last(last)
  );

  gtsa_scoreboard chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .source_id(source_id), .request_length(request_length),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .kind(kind), .granted_length(granted_length),
    .entry_owner(entry_owner), .entry_length(entry_length),
    .entry_start(entry_start), .cap_length(cap_length),
    .list_cleared(list_cleared), .last(last),
    .mismatch_count(mismatch_count), .beats_pending(beats_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Holds start until the block takes the beat; start stays high on return.
  task automatic send_item(input logic f, input logic [OWNER_W-1:0] id,
                           input logic [LEN_W-1:0] len);
    start <= 1'b1;
    func <= f;
    source_id <= id;
    request_length <= len;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every predicted beat is back, then lets the pipeline empty.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int total, input int base, input int floor,
                            input int order);
    cfg_we <= 1'b1;
    cfg_index <= REG_TOTAL_SLOTS;
    cfg_data <= CFG_DATA_W'(total);
    @(posedge clk);
    cfg_index <= REG_BASE_SLOT_DUR;
    cfg_data <= CFG_DATA_W'(base);
    @(posedge clk);
    cfg_index <= REG_MIN_CAP;
    cfg_data <= CFG_DATA_W'(floor);
    @(posedge clk);
    cfg_index <= REG_SF_ORDER;
    cfg_data <= CFG_DATA_W'(order);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly requests from a small set of owners so that grants get matched,
  // resized and refused; bursts of beats with random gaps in between.
  task automatic run_random(input int items);
    int                 left;
    int                 burst;
    logic               f;
    logic [OWNER_W-1:0] id;
    logic [LEN_W-1:0]   len;
    burst = $urandom_range(1, 12);
    for (left = items; left > 0; left--) begin
      f = ($urandom_range(0, 3) == 0) ? FUNC_BEACON : FUNC_REQUEST;
      id = ($urandom_range(0, 6) == 0) ? OWNER_W'($urandom) : id_pool[$urandom_range(0, 9)];
      len = ($urandom_range(0, 2) == 0) ? LEN_W'($urandom_range(0, 15))
                                        : LEN_W'($urandom_range(0, 4));
      send_item(f, id, len);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 40) == 0)
          settle();
        else if ($urandom_range(0, 3) != 0)
          pause($urandom_range(1, 14));
      end
    end
  endtask

  initial begin
    int p;
    int i;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (i = 2; i < 10; i++) id_pool[i] = OWNER_W'($urandom);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: need (16 - used - asked) * 60 >= 440
    send_item(FUNC_BEACON, 16'h0000, 4'd0);
    send_item(FUNC_REQUEST, 16'h0000, 4'd0);
    send_item(FUNC_REQUEST, 16'hFFFF, 4'd15);
    send_item(FUNC_REQUEST, 16'h1234, 4'd8);
    send_item(FUNC_REQUEST, 16'h1234, 4'd8);
    send_item(FUNC_REQUEST, 16'h0002, 4'd1);
    send_item(FUNC_REQUEST, 16'h1234, 4'd3);
    send_item(FUNC_BEACON, 16'hFFFF, 4'd15);
    settle();

    // six grants of 9, a refused 15, then a seventh grant fills the table for the beacons
    set_config(63, 1, 0, 0);
    for (i = 0; i < 6; i++) send_item(FUNC_REQUEST, OWNER_W'(16'h0100 + i), 4'd9);
    send_item(FUNC_REQUEST, 16'h1234, 4'd15);
    send_item(FUNC_BEACON, 16'h0000, 4'd0);
    send_item(FUNC_REQUEST, 16'h0000, 4'd3);
    send_item(FUNC_BEACON, 16'h0000, 4'd0);
    send_item(FUNC_BEACON, 16'h0000, 4'd0);
    settle();

    set_config(63, 1023, 65535, 14);
    send_item(FUNC_REQUEST, 16'hFFFF, 4'd15);
    send_item(FUNC_REQUEST, 16'h0001, 4'd0);
    send_item(FUNC_BEACON, 16'h0000, 4'd0);
    settle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:  set_config(63, 1, 0, 0);
        1:  set_config(40, 1, 0, 3);
        2:  set_config(20, 60, 440, 0);
        3:  set_config(63, 1023, 65535, 14);
        4:  set_config(1, 1, 0, 0);
        5:  set_config(63, 2, 100, 1);
        6:  set_config(30, 10, 0, 15);
        7:  set_config(0, 5, 0, 2);
        8:  set_config(16, 60, 440, 0);
        9:  set_config(48, 1, 1, 0);
        default: set_config($urandom_range(1, 63), $urandom_range(1, 1023),
                            $urandom_range(0, 65535), $urandom_range(0, 14));
      endcase
      run_random(PHASE_ITEMS);
      settle();
    end

    if (mismatch_count == 0 && beats_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: gts_slot_allocator.f
src/gtsa_pkg.sv
src/gtsa_regs.sv
src/gtsa_ctrl.sv
src/gtsa_dp.sv
src/gts_slot_allocator.sv
src/gtsa_checker.sv
tb/sv/gtsa_checker.sv
tb/sv/testbench.sv
